// File: rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is low
`define SBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slab allocator check failed");

// property checked on every rising edge, reset included
`define SBA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("slab allocator check failed");

`endif

// File: rtl/core/sba_pkg.sv
// shared constants, types and helper functions of the slab allocator
package sba_pkg;

  localparam int SLAB_COUNT     = 16;
  localparam int SLAB_BYTES     = 4096;
  localparam int OBJECT_BYTES   = 256;
  localparam int SLOTS_PER_SLAB = SLAB_BYTES / OBJECT_BYTES;
  localparam int OBJS_PER_SLAB  = (SLOTS_PER_SLAB > 1) ? SLOTS_PER_SLAB - 1 : 1;
  localparam int REGION_BYTES   = SLAB_COUNT * SLAB_BYTES;

  localparam int SLAB_W  = $clog2(SLAB_COUNT);
  localparam int SLOT_W  = $clog2(SLOTS_PER_SLAB);
  localparam int CNT_W   = $clog2(OBJS_PER_SLAB + 1);
  localparam int SLAB_SH = $clog2(SLAB_BYTES);
  localparam int OBJ_SH  = $clog2(OBJECT_BYTES);

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_ADDR     = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_NO_MEMORY    = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // one slab entry: free bit per object plus free count
  typedef struct packed {
    logic [OBJS_PER_SLAB-1:0] free_bits;
    logic [CNT_W-1:0]         avail_cnt;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLAB_W-1:0] idx;
    entry_t            data;
  } entry_wr_t;

  localparam entry_t ENTRY_RESET = '{
    free_bits: {OBJS_PER_SLAB{1'b1}},
    avail_cnt: CNT_W'(OBJS_PER_SLAB)
  };

  // lowest set bit of a slab bitmap
  function automatic logic [SLAB_W-1:0] lowest_slab(input logic [SLAB_COUNT-1:0] mask);
    logic [SLAB_W-1:0] idx;
    idx = '0;
    for (int i = SLAB_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = SLAB_W'(i);
      end
    end
    return idx;
  endfunction

  // lowest set bit of an object free bitmap
  function automatic logic [SLOT_W-1:0] lowest_obj(input logic [OBJS_PER_SLAB-1:0] bits);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = OBJS_PER_SLAB - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/slab_bitmap_allocator_unit.sv
// slab allocator top level: request decode, read-modify-write of the slab entry, result register
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tuser: op, tdata: object_address
//  out_    | out | out_tvalid/out_tready | tuser: status, tdata: granted_address
//  cfg_    | in  | cfg_wr_en           | cfg_wr_data: base_address
//
// a request is handled in order: the accept cycle decodes it and reads the slab entry,
// then the S_EXEC state modifies and writes back the entry and loads the result register
// the split is set by the registered read of the slab entry memory
// a waiting result holds the write-back cycle until out_tready, in_tready stays low meanwhile
// reset marks every slab empty and clears the entry valid bits, no sweep
module slab_bitmap_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,    // op
  input  logic [31:0] in_tdata,    // object_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,   // status
  output logic [31:0] out_tdata,   // granted_address
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data  // base_address
);

  localparam int N    = sba_pkg::SLAB_COUNT;
  localparam int OBJS = sba_pkg::OBJS_PER_SLAB;

  // configuration
  logic [31:0] base_r;

  // slab class bitmaps
  logic [N-1:0] empty_r, partial_r, full_r;
  logic [N-1:0] empty_nxt, partial_nxt, full_nxt;

  // request held across the read cycle
  sba_pkg::op_t                op_r;
  logic [sba_pkg::SLAB_W-1:0]  slab_r;
  logic [sba_pkg::SLOT_W-1:0]  obj_r;
  logic                        early_fail_r;
  sba_pkg::status_t            early_status_r;

  sba_pkg::state_t state_r, state_nxt;

  // result register
  logic             out_valid_r;
  sba_pkg::status_t out_status_r;
  logic [31:0]      out_addr_r;

  // decode signals
  logic                        accept;
  logic                        commit;
  logic [31:0]                 offset;
  logic [sba_pkg::SLAB_W-1:0]  rel_slab;
  logic [sba_pkg::SLOT_W-1:0]  rel_slot;
  logic                        rel_bad;
  logic [N-1:0]                alloc_mask;
  logic [sba_pkg::SLAB_W-1:0]  alloc_slab;
  logic [sba_pkg::SLAB_W-1:0]  dec_slab;

  // modify signals
  sba_pkg::entry_t             rd_entry;
  sba_pkg::entry_t             new_entry;
  sba_pkg::entry_wr_t          wr;
  logic [sba_pkg::SLOT_W-1:0]  obj_sel;
  logic [OBJS-1:0]             obj_bit;
  sba_pkg::status_t            exec_status;
  logic [31:0]                 exec_addr;
  logic [N-1:0]                slab_bit;

  assign in_tready = (state_r == sba_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // release decode: region offset, slab and slot fields
  assign offset   = in_tdata - base_r;
  assign rel_slab = offset[sba_pkg::SLAB_SH +: sba_pkg::SLAB_W];
  assign rel_slot = offset[sba_pkg::OBJ_SH +: sba_pkg::SLOT_W];
  assign rel_bad  = (offset >= 32'(sba_pkg::REGION_BYTES)) ||
                    (rel_slot == '0) ||
                    (32'(rel_slot) > 32'(OBJS));

  // allocate decode: lowest partial slab first, else lowest empty slab
  assign alloc_mask = (partial_r != '0) ? partial_r : empty_r;
  assign alloc_slab = sba_pkg::lowest_slab(alloc_mask);

  assign dec_slab = (sba_pkg::op_t'(in_tuser[0]) == sba_pkg::OP_RELEASE) ? rel_slab : alloc_slab;

  sba_slab_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (dec_slab),
    .wr      (wr),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= sba_pkg::op_t'(in_tuser[0]);
      slab_r <= dec_slab;
      obj_r  <= rel_slot - sba_pkg::SLOT_W'(1);
      if (sba_pkg::op_t'(in_tuser[0]) == sba_pkg::OP_RELEASE) begin
        early_fail_r   <= rel_bad;
        early_status_r <= sba_pkg::ST_BAD_ADDR;
      end else begin
        early_fail_r   <= (alloc_mask == '0);
        early_status_r <= sba_pkg::ST_NO_MEMORY;
      end
    end
  end

  // state machine and the modify step of the slab entry
  always_comb begin
    state_nxt   = state_r;
    commit      = 1'b0;
    obj_sel     = (op_r == sba_pkg::OP_RELEASE) ? obj_r : sba_pkg::lowest_obj(rd_entry.free_bits);
    obj_bit     = OBJS'(1) << obj_sel;
    new_entry   = rd_entry;
    exec_status = sba_pkg::ST_OK;
    exec_addr   = '0;
    wr          = '0;

    if (early_fail_r) begin
      exec_status = early_status_r;
    end else if (op_r == sba_pkg::OP_ALLOC) begin
      if (rd_entry.free_bits == '0) begin
        // only reachable if the classes went out of step
        exec_status = sba_pkg::ST_NO_MEMORY;
      end else begin
        new_entry.free_bits = rd_entry.free_bits & ~obj_bit;
        new_entry.avail_cnt = rd_entry.avail_cnt - sba_pkg::CNT_W'(1);
        exec_addr = base_r + (32'(slab_r) << sba_pkg::SLAB_SH) +
                    ((32'(obj_sel) + 32'd1) << sba_pkg::OBJ_SH);
      end
    end else begin
      if ((rd_entry.free_bits & obj_bit) != '0) begin
        exec_status = sba_pkg::ST_ALREADY_FREE;
      end else begin
        new_entry.free_bits = rd_entry.free_bits | obj_bit;
        new_entry.avail_cnt = rd_entry.avail_cnt + sba_pkg::CNT_W'(1);
      end
    end

    case (state_r)
      sba_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = sba_pkg::S_EXEC;
        end
      end
      sba_pkg::S_EXEC: begin
        if (!out_valid_r || out_tready) begin
          commit    = 1'b1;
          state_nxt = sba_pkg::S_IDLE;
          wr.en     = (exec_status == sba_pkg::ST_OK);
          wr.idx    = slab_r;
          wr.data   = new_entry;
        end
      end
      default: begin
        state_nxt = sba_pkg::S_IDLE;
      end
    endcase
  end

  // reclassify the touched slab from its new free count
  always_comb begin
    slab_bit    = N'(1) << slab_r;
    empty_nxt   = empty_r;
    partial_nxt = partial_r;
    full_nxt    = full_r;
    if (wr.en) begin
      empty_nxt   = empty_r & ~slab_bit;
      partial_nxt = partial_r & ~slab_bit;
      full_nxt    = full_r & ~slab_bit;
      if (new_entry.avail_cnt == '0) begin
        full_nxt = full_nxt | slab_bit;
      end else if (new_entry.avail_cnt == sba_pkg::CNT_W'(OBJS)) begin
        empty_nxt = empty_nxt | slab_bit;
      end else begin
        partial_nxt = partial_nxt | slab_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sba_pkg::S_IDLE;
      base_r    <= '0;
      empty_r   <= '1;
      partial_r <= '0;
      full_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      empty_r   <= empty_nxt;
      partial_r <= partial_nxt;
      full_r    <= full_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  // result register: loads on commit, drops when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= exec_status;
      out_addr_r   <= exec_addr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_addr_r;

endmodule

// File: rtl/core/sba_slab_store.sv
// per-slab entry memory with valid bits standing in for the reset contents
module sba_slab_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [sba_pkg::SLAB_W-1:0]  rd_idx,
  input  sba_pkg::entry_wr_t          wr,
  output sba_pkg::entry_t             rd_data
);

  sba_pkg::entry_t                    mem [sba_pkg::SLAB_COUNT];
  logic [sba_pkg::SLAB_COUNT-1:0]     valid_r;
  sba_pkg::entry_t                    rd_q_r;
  logic                               rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  // never written entries read as all free
  assign rd_data = rd_valid_r ? rd_q_r : sba_pkg::ENTRY_RESET;

endmodule

// File: rtl/core/sba_checker.sv
// port-level checks on the slab allocator, bound to the top level
`include "assert_macros.svh"

module sba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [1:0]  out_tuser,
  input logic [31:0] out_tdata
);

  // a stalled result beat holds its payload
  `SBA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // no result comes out of reset
  `SBA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid)

  // only a successful allocation carries an address
  `SBA_ASSERT(a_addr_zero, clk, rst_n, out_tvalid && out_tuser != sba_pkg::ST_OK |-> out_tdata == 32'd0)

  // one request in flight: the beat after an accept is never taken at once
  `SBA_ASSERT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

endmodule

bind slab_bitmap_allocator_unit sba_checker u_sba_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tuser   (out_tuser),
  .out_tdata   (out_tdata)
);

// File: verif/tb_slab_bitmap_allocator_unit.sv
// self-checking testbench of the slab allocator: directed table, then randomized phases
module tb_slab_bitmap_allocator_unit;

  // slowest run: ~1950 beats, each with a random input gap, a random output stall and its pass
  // through the block, plus two long receiver hold-offs; the limit below bounds the whole run
  localparam longint RUN_LIMIT   = 64'd5_000_000;
  localparam int     HOLD_CYCLES = 80;
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 240;
  localparam int     DIR_ROWS    = 25;

  typedef enum bit {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  // one row of the directed table; value is the request address or the new base
  typedef struct packed {
    row_kind_e        kind;
    sba_pkg::op_t     op;
    logic [31:0]      value;
    bit               has_fixed;
    sba_pkg::status_t st;
    logic [31:0]      grant;
  } dir_row_t;

  typedef struct {
    sba_pkg::status_t st;
    logic [31:0]      grant;
  } reply_t;

  // clock and every block input start from known values
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [0:0]  in_tuser    = sba_pkg::OP_ALLOC;  // op
  logic [31:0] in_tdata    = '0;        // object_address
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [1:0]  out_tuser;               // status
  logic [31:0] out_tdata;               // granted_address
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;        // base_address

  always #5 clk = ~clk;

  slab_bitmap_allocator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // mirror of the allocator: class bitmaps, per-slab free bits and counts, base register
  logic [31:0]                       base_addr;
  logic [sba_pkg::SLAB_COUNT-1:0]    empty_map;
  logic [sba_pkg::SLAB_COUNT-1:0]    partial_map;
  logic [sba_pkg::SLAB_COUNT-1:0]    full_map;
  logic [sba_pkg::OBJS_PER_SLAB-1:0] obj_free [sba_pkg::SLAB_COUNT];
  int                                free_cnt [sba_pkg::SLAB_COUNT];

  // replies still owed by the block, oldest first
  reply_t reply_q [$];

  int n_errors;
  int n_items;
  int n_cfg;
  int status_tally [4];

  // stimulus knobs shared between the two sides
  bit tx_burst;
  bit rx_hold_req;
  bit rx_calm;

  // directed table: expected reply typed in where it is obvious, else left to the mirror
  dir_row_t dir_rows [DIR_ROWS] = '{
    // base 0 after reset: first grant is slab 0, object 0
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, sba_pkg::ST_OK, 32'h0000_0100},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_0100, 1'b1, sba_pkg::ST_OK, 32'h0000_0000},
    // double free
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_0100, 1'b1, sba_pkg::ST_ALREADY_FREE, 32'h0},
    // descriptor slots of slab 0 and slab 1
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_0000, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_1000, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    // first byte past the region, and the top address
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0001_0000, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'hFFFF_FFFF, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, sba_pkg::ST_OK, 32'h0000_0100},
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, sba_pkg::ST_OK, 32'h0000_0200},
    // last byte of object 0 still names object 0
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_01FF, 1'b1, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, sba_pkg::ST_OK, 32'h0000_0100},
    // last object of the last slab, never handed out
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_FFFF, 1'b1, sba_pkg::ST_ALREADY_FREE, 32'h0},
    // address field of an allocate is don't care
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, sba_pkg::ST_OK, 32'h0000_0300},
    // top base: grants wrap around 2^32
    '{ROW_CFG, sba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b0, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, sba_pkg::ST_OK, 32'h0000_03FF},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_03FF, 1'b1, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_0000, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    // one below base wraps to the largest offset
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'hFFFF_FFFE, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_FFFE, 1'b1, sba_pkg::ST_ALREADY_FREE, 32'h0},
    '{ROW_CFG, sba_pkg::OP_ALLOC, 32'h0001_0000, 1'b0, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0001_0100, 1'b1, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0000_0000, 1'b1, sba_pkg::ST_BAD_ADDR, 32'h0},
    '{ROW_REQ, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_REQ, sba_pkg::OP_RELEASE, 32'h0001_0203, 1'b0, sba_pkg::ST_OK, 32'h0000_0000},
    '{ROW_CFG, sba_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, sba_pkg::ST_OK, 32'h0000_0000}
  };

  // put a slab back in the class its free count calls for
  function automatic void sort_slab(input int slab);
    empty_map[slab]   = 1'b0;
    partial_map[slab] = 1'b0;
    full_map[slab]    = 1'b0;
    if (free_cnt[slab] == 0) begin
      full_map[slab] = 1'b1;
    end else if (free_cnt[slab] == sba_pkg::OBJS_PER_SLAB) begin
      empty_map[slab] = 1'b1;
    end else begin
      partial_map[slab] = 1'b1;
    end
  endfunction

  // apply one request to the mirror and work out the reply it earns
  function automatic void apply_request(input sba_pkg::op_t op, input logic [31:0] addr,
                                        output sba_pkg::status_t st,
                                        output logic [31:0] grant);
    int          slab;
    int          obj;
    int          slot;
    logic [31:0] off;
    st    = sba_pkg::ST_OK;
    grant = '0;
    slab  = -1;
    obj   = -1;
    if (op == sba_pkg::OP_ALLOC) begin
      // lowest partial slab wins, lowest empty slab otherwise
      for (int i = sba_pkg::SLAB_COUNT - 1; i >= 0; i--) if (empty_map[i]) slab = i;
      for (int i = sba_pkg::SLAB_COUNT - 1; i >= 0; i--) if (partial_map[i]) slab = i;
      if (slab < 0) begin
        st = sba_pkg::ST_NO_MEMORY;
      end else begin
        for (int j = sba_pkg::OBJS_PER_SLAB - 1; j >= 0; j--) if (obj_free[slab][j]) obj = j;
        obj_free[slab][obj] = 1'b0;
        free_cnt[slab]--;
        sort_slab(slab);
        grant = base_addr + 32'(slab * sba_pkg::SLAB_BYTES) +
                32'((obj + 1) * sba_pkg::OBJECT_BYTES);
      end
    end else begin
      // offset wraps, so addresses below base land far past the region
      off = addr - base_addr;
      if (off >= 32'(sba_pkg::REGION_BYTES)) begin
        st = sba_pkg::ST_BAD_ADDR;
      end else begin
        slab = int'(off / sba_pkg::SLAB_BYTES);
        slot = int'((off % sba_pkg::SLAB_BYTES) / sba_pkg::OBJECT_BYTES);
        if (slot == 0 || slot > sba_pkg::OBJS_PER_SLAB) begin
          st = sba_pkg::ST_BAD_ADDR;
        end else if (obj_free[slab][slot-1]) begin
          st = sba_pkg::ST_ALREADY_FREE;
        end else begin
          obj_free[slab][slot-1] = 1'b1;
          free_cnt[slab]++;
          sort_slab(slab);
        end
      end
    end
  endfunction

  // release address: mostly an object that is out, else double frees and bad addresses
  function automatic logic [31:0] pick_release_addr();
    int          kind;
    int          slab;
    int          obj;
    bit          want_free;
    logic [31:0] low;
    kind      = $urandom_range(0, 99);
    slab      = $urandom_range(0, sba_pkg::SLAB_COUNT - 1);
    obj       = $urandom_range(0, sba_pkg::OBJS_PER_SLAB - 1);
    low       = $urandom_range(0, sba_pkg::OBJECT_BYTES - 1);
    want_free = (kind >= 70);
    if (kind < 80) begin
      for (int t = 0; t < 32 && (obj_free[slab][obj] != want_free); t++) begin
        slab = $urandom_range(0, sba_pkg::SLAB_COUNT - 1);
        obj  = $urandom_range(0, sba_pkg::OBJS_PER_SLAB - 1);
      end
    end else if (kind < 86) begin
      // descriptor slot
      return base_addr + 32'(slab * sba_pkg::SLAB_BYTES) + low;
    end else if (kind < 90) begin
      return base_addr + 32'(sba_pkg::REGION_BYTES) + 32'($urandom_range(0, 4095));
    end else if (kind < 94) begin
      return base_addr - 32'($urandom_range(1, 4096));
    end else begin
      return $urandom;
    end
    return base_addr + 32'(slab * sba_pkg::SLAB_BYTES) +
           32'((obj + 1) * sba_pkg::OBJECT_BYTES) + low;
  endfunction

  // offer one request after a random gap, none in burst mode; on the accepting edge log what it should return
  task automatic send_request(input sba_pkg::op_t op, input logic [31:0] addr,
                              input bit has_fixed, input sba_pkg::status_t fixed_st,
                              input logic [31:0] fixed_grant);
    int     gap;
    reply_t r;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    // valid drops only when a gap follows, so it is never lowered and raised in one step
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    apply_request(op, addr, r.st, r.grant);
    status_tally[r.st]++;
    if (has_fixed) begin
      r.st    = fixed_st;
      r.grant = fixed_grant;
    end
    reply_q.push_back(r);
    n_items++;
  endtask

  // new base only once every reply is home, so the block is idle
  task automatic write_base(input logic [31:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_addr = value;
    n_cfg++;
  endtask

  // receiver: random per-beat stall, calm stretches, long hold-off on request
  initial begin : rx_side
    int stall;
    int beats;
    beats = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (beats % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (rx_hold_req) begin
        // hold the output long enough for the block to back up into its input
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats++;
    end
  end

  // reply checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected reply, expected none, got status %0d grant %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = reply_q.pop_front();
        if (out_tuser !== want.st) begin
          n_errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.st, out_tuser);
        end
        if (out_tdata !== want.grant) begin
          n_errors++;
          $display("%0t: grant mismatch, expected %h, got %h",
                   $time, want.grant, out_tdata);
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [31:0]  next_base;
    int           alloc_pct;
    sba_pkg::op_t op;
    n_errors    = 0;
    n_items     = 0;
    n_cfg       = 0;
    tx_burst    = 1'b0;
    rx_hold_req = 1'b0;
    rx_calm     = 1'b0;
    base_addr   = '0;
    empty_map   = '1;
    partial_map = '0;
    full_map    = '0;
    for (int s = 0; s < sba_pkg::SLAB_COUNT; s++) begin
      obj_free[s] = '1;
      free_cnt[s] = sba_pkg::OBJS_PER_SLAB;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_base(dir_rows[r].value);
      end else begin
        send_request(dir_rows[r].op, dir_rows[r].value, dir_rows[r].has_fixed,
                     dir_rows[r].st, dir_rows[r].grant);
      end
    end

    // random phases: each one drains, moves the base, then runs with its own alloc mix;
    // the first two fill every slab so out of memory shows up, later ones drain and refill
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       next_base = 32'h0000_0000;
        1:       next_base = $urandom;
        2:       next_base = 32'hFFFF_0000 + ($urandom & 32'h0000_FF00);  // region wraps
        default: next_base = 32'hFFFF_FFFF;
      endcase
      case (p)
        0:       alloc_pct = 95;
        1:       alloc_pct = 90;
        2:       alloc_pct = 30;
        3:       alloc_pct = 60;
        4:       alloc_pct = 20;
        5:       alloc_pct = 92;
        6:       alloc_pct = 50;
        default: alloc_pct = 85;
      endcase
      write_base(next_base);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        // back-to-back offers while the receiver holds off
        if ((p == 3 || p == 6) && i == 96) rx_hold_req = 1'b1;
        if ((p == 3 || p == 6) && i >= 96 && i < 136) tx_burst = 1'b1;
        op = ($urandom_range(0, 99) < alloc_pct) ? sba_pkg::OP_ALLOC : sba_pkg::OP_RELEASE;
        send_request(op, (op == sba_pkg::OP_ALLOC) ? $urandom : pick_release_addr(),
                     1'b0, sba_pkg::ST_OK, 32'h0);
      end
    end

    // drain, then a short quiet window to catch stray beats
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
    repeat (10) @(posedge clk);
    if (reply_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d replies never arrived", $time, reply_q.size());
    end

    $display("run covered %0d requests over %0d base settings: %0d ok, %0d bad address,",
             n_items, n_cfg, status_tally[sba_pkg::ST_OK], status_tally[sba_pkg::ST_BAD_ADDR]);
    $display("  %0d double free, %0d out of memory, %0d check failures",
             status_tally[sba_pkg::ST_ALREADY_FREE], status_tally[sba_pkg::ST_NO_MEMORY],
             n_errors);
    if (n_errors == 0) begin
      $display("tb_slab_bitmap_allocator_unit: done, clean");
    end else begin
      $display("tb_slab_bitmap_allocator_unit: done, errors");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("tb_slab_bitmap_allocator_unit: done, errors");
    $finish;
  end

endmodule
